/* rtl/assert_macros.svh */
// Assertion macros for the checker module of the E2E CRC block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLKRST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property checked at every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* rtl/e2ec_pkg.sv */
// Package of the E2E CRC-32 protect/check block: types, constants, CRC functions.
// No dependencies.
package e2ec_pkg;

  localparam int unsigned CRC_W    = 32;
  localparam int unsigned DID_W    = 16;
  localparam int unsigned MD_W     = 7;
  localparam int unsigned SC_W     = 8;
  localparam int unsigned CTR_W    = 4;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hC8DF352F;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

  // Byte positions within a frame.
  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_CTR   = 3'd4;
  localparam logic [POS_W-1:0] POS_PAY   = 3'd6;
  localparam logic [POS_W-1:0] POS_SAT   = 3'd7;

  // Operation code bits: bit 1 selects check, bit 0 selects forward.
  localparam int unsigned OP_FWD_BIT   = 0;
  localparam int unsigned OP_CHECK_BIT = 1;

  localparam logic [MD_W-1:0]  MAX_DELTA_RST = 7'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_REPEATED    = 3'd1,
    ST_WRONG_SEQ   = 3'd2,
    ST_WRONG_CRC   = 3'd3,
    ST_NO_NEW_DATA = 3'd4
  } status_e;

  typedef enum logic {
    REG_DATA_ID   = 1'b0,
    REG_MAX_DELTA = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [7:0]        data_byte;
    logic              last_byte;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [CRC_W-1:0]   crc_value;
    logic [CTR_W-1:0]   counter_value;
  } res_word_t;

  typedef struct packed {
    logic [DID_W-1:0] data_id;
    logic [MD_W-1:0]  max_delta;
  } cfg_t;

  // One byte of the reflected CRC, unrolled into an xor network.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC over the four header bytes, from the initial value.
  function automatic logic [CRC_W-1:0] crc_header(input logic [DID_W-1:0] did,
                                                  input logic [7:0] cnt_byte);
    logic [CRC_W-1:0] c;
    c = crc_byte(CRC_ONES, did[15:8]);
    c = crc_byte(c, did[7:0]);
    c = crc_byte(c, cnt_byte);
    c = crc_byte(c, did[7:0]);
    return c;
  endfunction

endpackage

/* rtl/e2ec_in_if.sv */
// Input channel of the E2E CRC block: one frame byte per word.
// Depends on e2ec_pkg.
interface e2ec_in_if;
  import e2ec_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [7:0]        data_byte;
  logic              last_byte;

  modport source (output valid, func, data_byte, last_byte, input ready);
  modport sink (input valid, func, data_byte, last_byte, output ready);
endinterface

/* rtl/e2ec_out_if.sv */
// Result channel of the E2E CRC block: one word per frame.
// Depends on e2ec_pkg.
interface e2ec_out_if;
  import e2ec_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CRC_W-1:0]    crc_value;
  logic [CTR_W-1:0]    counter_value;

  modport source (output valid, status, crc_value, counter_value, input ready);
  modport sink (input valid, status, crc_value, counter_value, output ready);
endinterface

/* rtl/e2e_crc32_protect_check_top.sv */
// E2E protection and check with a reflected CRC-32 over a byte stream.
// Frame bytes enter on in_i, one per word; the operation (protect, forward
// or check) is taken from the func field of the first byte of a frame, and
// last_byte closes the frame. A frame gives one result word on out_o:
// status, header CRC and counter. Protect and forward report the header to
// send; check reports the judgement of the received header.
// Registers data_id (address 0) and max_delta (address 4) sit on the APB
// port; write them only while no word is in flight in the block.
// Throughput is one byte per cycle unless the receiver stalls: the byte-wide
// CRC update and the header hash are combinational xor networks between the
// input register and the result register. The result word of a frame is
// offered from the result register after its last byte has passed both.
// Reset clears the counters, sets running CRC to all ones, data_id to 0 and
// max_delta to 1. When the receiver stalls, the result register holds its
// word, the input register takes at most one more byte, and then
// in_i.ready drops.
module e2e_crc32_protect_check_top #(
  parameter int unsigned COUNTER_MAX = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  e2ec_in_if.sink                        in_i,
  e2ec_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [e2ec_pkg::PADDR_W-1:0]   paddr,
  input  logic [e2ec_pkg::PDATA_W-1:0]   pwdata,
  output logic [e2ec_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import e2ec_pkg::*;

  cfg_t      cfg;
  in_word_t  in_word, core_word;
  res_word_t core_res, out_res;
  logic      core_valid, fire, room, res_valid;

  e2ec_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_word.func      = in_i.func;
  assign in_word.data_byte = in_i.data_byte;
  assign in_word.last_byte = in_i.last_byte;

  e2ec_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .word_i  (in_word),
    .valid_o (core_valid),
    .take_i  (fire),
    .word_o  (core_word)
  );

  // The core advances whenever it holds a byte and the result register can take a word.
  assign fire = core_valid && room;

  e2ec_core #(
    .COUNTER_MAX (COUNTER_MAX)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .word_i      (core_word),
    .res_valid_o (res_valid),
    .res_o       (core_res)
  );

  e2ec_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (core_res),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.status        = out_res.status;
  assign out_o.crc_value     = out_res.crc_value;
  assign out_o.counter_value = out_res.counter_value;
endmodule

/* rtl/e2ec_cfg.sv */
// APB-style configuration registers: data id and maximum counter step.
// Depends on e2ec_pkg.
module e2ec_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [e2ec_pkg::PADDR_W-1:0]   paddr,
  input  logic [e2ec_pkg::PDATA_W-1:0]   pwdata,
  output logic [e2ec_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output e2ec_pkg::cfg_t                 cfg_o
);
  import e2ec_pkg::*;

  reg_idx_e         idx;
  logic             wr_en;
  logic [DID_W-1:0] data_id_q;
  logic [MD_W-1:0]  max_delta_q;

  // Registers sit on 32-bit word boundaries; the low address bits are ignored.
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_id_q   <= '0;
      max_delta_q <= MAX_DELTA_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DATA_ID:   data_id_q   <= pwdata[DID_W-1:0];
        REG_MAX_DELTA: max_delta_q <= pwdata[MD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DATA_ID:   prdata = {{(PDATA_W-DID_W){1'b0}}, data_id_q};
      REG_MAX_DELTA: prdata = {{(PDATA_W-MD_W){1'b0}}, max_delta_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.data_id   = data_id_q;
  assign cfg_o.max_delta = max_delta_q;
endmodule

/* rtl/e2ec_in_reg.sv */
// Input register: holds one accepted frame byte until the core takes it.
// Depends on e2ec_pkg.
module e2ec_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  e2ec_pkg::in_word_t  word_i,
  output logic                valid_o,
  input  logic                take_i,
  output e2ec_pkg::in_word_t  word_o
);
  import e2ec_pkg::*;

  logic     valid_q;
  in_word_t word_q;

  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule

/* rtl/e2ec_core.sv */
// Frame state, byte-wide CRC update, counter handling and check judgement.
// Depends on e2ec_pkg.
module e2ec_core #(
  parameter int unsigned COUNTER_MAX = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  e2ec_pkg::cfg_t       cfg_i,
  input  logic                 fire_i,
  input  e2ec_pkg::in_word_t   word_i,
  output logic                 res_valid_o,
  output e2ec_pkg::res_word_t  res_o
);
  import e2ec_pkg::*;

  logic [CRC_W-1:0]  crc_q, crc_base, crc_new, crc_out;
  logic [POS_W-1:0]  pos_q;
  logic [FUNC_W-1:0] op_q, op;
  logic [SC_W-1:0]   sc_q, sc_d;
  logic [CTR_W-1:0]  cc_q, cc_d;
  logic [CRC_W-1:0]  hcrc_q, hcrc_new;
  logic [CTR_W-1:0]  hctr_q, hctr_new;
  logic [CTR_W-1:0]  diff;
  logic              is_check;
  logic [7:0]        b;

  assign b = word_i.data_byte;

  always_comb begin
    op       = (pos_q == POS_FIRST) ? word_i.func : op_q;
    is_check = op[OP_CHECK_BIT];
    sc_d     = sc_q;
    hctr_new = hctr_q;
    hcrc_new = hcrc_q;
    crc_base = crc_q;
    crc_new  = crc_q;

    if (!is_check) begin
      if (pos_q == POS_FIRST) begin
        if (op[OP_FWD_BIT]) begin
          hctr_new = cc_q;
          sc_d     = {{(SC_W-CTR_W){1'b0}}, cc_q};
        end else begin
          sc_d     = (sc_q < SC_W'(COUNTER_MAX)) ? sc_q + 8'd1 : '0;
          hctr_new = sc_d[CTR_W-1:0];
        end
        crc_base = crc_header(cfg_i.data_id, {{(8-CTR_W){1'b0}}, hctr_new});
      end
      crc_new = crc_byte(crc_base, b);
    end else begin
      // Bytes 0-3 carry the received CRC, byte 4 the counter, byte 5 is skipped.
      priority if (pos_q < POS_CTR) begin
        hcrc_new[{pos_q[1:0], 3'b000} +: 8] = b;
      end else if (pos_q == POS_CTR) begin
        hctr_new = b[CTR_W-1:0];
        crc_new  = crc_header(cfg_i.data_id, b);
      end else if (pos_q >= POS_PAY) begin
        crc_new = crc_byte(crc_q, b);
      end else begin
        crc_new = crc_q;
      end
    end

    crc_out             = crc_new ^ CRC_ONES;
    diff                = hctr_new - cc_q;
    cc_d                = cc_q;
    res_o.status        = ST_OK;
    res_o.crc_value     = crc_out;
    res_o.counter_value = hctr_new;

    if (is_check) begin
      priority if (pos_q < POS_PAY) begin
        res_o.status        = ST_NO_NEW_DATA;
        res_o.crc_value     = '0;
        res_o.counter_value = '0;
      end else if (crc_out != hcrc_new) begin
        res_o.status = ST_WRONG_CRC;
      end else begin
        cc_d = hctr_new;
        priority if (hctr_new == cc_q) begin
          res_o.status = ST_REPEATED;
        end else if (hctr_new < cc_q) begin
          res_o.status = ST_WRONG_SEQ;
        end else if ({{(MD_W-CTR_W){1'b0}}, diff} > cfg_i.max_delta) begin
          res_o.status = ST_WRONG_SEQ;
        end else begin
          res_o.status = ST_OK;
        end
      end
    end
  end

  assign res_valid_o = fire_i && word_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_ONES;
      pos_q  <= POS_FIRST;
      op_q   <= '0;
      sc_q   <= '0;
      cc_q   <= '0;
      hcrc_q <= '0;
      hctr_q <= '0;
    end else if (fire_i) begin
      op_q   <= op;
      sc_q   <= sc_d;
      hcrc_q <= hcrc_new;
      hctr_q <= hctr_new;
      if (word_i.last_byte) begin
        crc_q <= CRC_ONES;
        pos_q <= POS_FIRST;
        cc_q  <= cc_d;
      end else begin
        crc_q <= crc_new;
        // The position saturates at POS_SAT, inside the payload region.
        if (pos_q != POS_SAT) begin
          pos_q <= pos_q + 3'd1;
        end
      end
    end
  end
endmodule

/* rtl/e2ec_out_reg.sv */
// Result register: holds one result word until the receiver takes it.
// Depends on e2ec_pkg.
module e2ec_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  e2ec_pkg::res_word_t  res_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output e2ec_pkg::res_word_t  res_o
);
  import e2ec_pkg::*;

  logic      valid_q;
  res_word_t res_q;

  assign room_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (room_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

/* rtl/e2ec_checker.sv */
// Port-level checker for the E2E CRC block, bound to the top level.
// Depends on e2ec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module e2ec_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [e2ec_pkg::STATUS_W-1:0]  out_status,
  input logic [e2ec_pkg::CRC_W-1:0]     out_crc,
  input logic [e2ec_pkg::CTR_W-1:0]     out_ctr
);
  import e2ec_pkg::*;

  // A stalled result word stays offered.
  `ASSERT_CLKRST(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid)

  // A stalled result word keeps its value.
  `ASSERT_CLKRST(a_out_stable, clk_i, rst_ni, out_valid && !out_ready |=> $stable(out_status) && $stable(out_crc) && $stable(out_ctr))

  // A short check frame reports neither CRC nor counter.
  `ASSERT_CLKRST(a_nnd_zero, clk_i, rst_ni, out_valid && (out_status == ST_NO_NEW_DATA) |-> (out_crc == '0) && (out_ctr == '0))

  // No result word is offered right after reset.
  `ASSERT_CLK(a_rst_empty, clk_i, !rst_ni |=> !out_valid)
endmodule

bind e2e_crc32_protect_check_top e2ec_checker u_e2ec_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_status (out_o.status),
  .out_crc    (out_o.crc_value),
  .out_ctr    (out_o.counter_value)
);

/* tb/sv/tb_e2e_crc32_protect_check_top.sv */
// Self-checking testbench of e2e_crc32_protect_check_top: frames of protect, forward and check
// traffic, with random idling on both channels, checked word by word against a built-in model.
// Depends on e2ec_pkg, e2ec_in_if, e2ec_out_if and the top level of the block.
module tb_e2e_crc32_protect_check_top;
  import e2ec_pkg::*;

  localparam int unsigned CTR_LIMIT = 15;
  localparam logic [31:0] POLY_REFL = 32'hC8DF352F;

  typedef enum logic [FUNC_W-1:0] {
    OP_PROTECT = 2'd0,
    OP_FORWARD = 2'd1,
    OP_CHECK   = 2'd2,
    OP_SPARE   = 2'd3
  } op_e;

  localparam res_word_t IDLE_RES  = '{ST_OK, 32'd0, 4'd0};
  localparam res_word_t SHORT_RES = '{ST_NO_NEW_DATA, 32'd0, 4'd0};

  // Byte i of a frame sits at bits [8*i +: 8] of frame_bytes.
  typedef struct packed {
    op_e        func;
    logic [3:0] len;
    logic [63:0] frame_bytes;
    logic       sealed;
    logic       typed;
    res_word_t  want;
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  e2ec_in_if  in_if ();
  e2ec_out_if out_if ();

  e2e_crc32_protect_check_top #(
    .COUNTER_MAX(CTR_LIMIT)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model state: configuration copy and the frame state of the block.
  logic [15:0] m_did;
  logic [6:0]  m_maxd;
  logic [31:0] m_crc;
  logic [2:0]  m_pos;
  logic [1:0]  m_op;
  logic [7:0]  m_snd;
  logic [3:0]  m_chk;
  logic [31:0] m_rxcrc;
  logic [3:0]  m_rxctr;

  res_word_t   due_results[$];
  logic [7:0]  frame_q[$];
  op_e         frame_func;
  int          mismatch_cnt = 0;
  bit          hold_req = 1'b0;
  bit          calm = 1'b0;
  bit          burst = 1'b0;

  frame_row_t directed_rows [6] = '{
    '{OP_PROTECT, 4'd1, 64'h0000_0000_0000_0000, 1'b0, 1'b0, IDLE_RES},
    '{OP_FORWARD, 4'd1, 64'h0000_0000_0000_00FF, 1'b0, 1'b0, IDLE_RES},
    '{OP_CHECK,   4'd1, 64'h0000_0000_0000_005A, 1'b0, 1'b1, SHORT_RES},
    '{OP_SPARE,   4'd6, 64'h0000_A5C3_3CFF_00FF, 1'b0, 1'b1, SHORT_RES},
    '{OP_CHECK,   4'd7, 64'h0080_00F3_FFFF_FFFF, 1'b0, 1'b0, IDLE_RES},
    '{OP_CHECK,   4'd7, 64'h00FF_7E01_0000_0000, 1'b1, 1'b0, IDLE_RES}
  };

  function automatic logic [31:0] crc_shift_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    repeat (8) x = (x >> 1) ^ (POLY_REFL & {32{x[0]}});
    return x;
  endfunction

  function automatic logic [31:0] crc_of_header(logic [7:0] ctr_byte);
    logic [31:0] c;
    c = crc_shift_byte(CRC_ONES, m_did[15:8]);
    c = crc_shift_byte(c, m_did[7:0]);
    c = crc_shift_byte(c, ctr_byte);
    return crc_shift_byte(c, m_did[7:0]);
  endfunction

  // Advances the model by one accepted byte; returns 1 when the byte closes a frame.
  function automatic bit e2e_step(in_word_t w, output res_word_t r);
    logic [2:0]  p;
    logic        chk;
    logic [31:0] crc_out;
    p = m_pos;
    r = IDLE_RES;
    if (p == POS_FIRST) m_op = w.func;
    chk = m_op[OP_CHECK_BIT];
    if (!chk) begin
      if (p == POS_FIRST) begin
        if (m_op[OP_FWD_BIT]) begin
          m_rxctr = m_chk;
          m_snd = {4'h0, m_chk};
        end else begin
          m_snd = (m_snd < CTR_LIMIT) ? m_snd + 8'd1 : 8'd0;
          m_rxctr = m_snd[3:0];
        end
        m_crc = crc_of_header({4'h0, m_rxctr});
      end
      m_crc = crc_shift_byte(m_crc, w.data_byte);
    end else if (p < POS_CTR) begin
      m_rxcrc[8*p +: 8] = w.data_byte;
    end else if (p == POS_CTR) begin
      m_rxctr = w.data_byte[3:0];
      m_crc = crc_of_header(w.data_byte);
    end else if (p >= POS_PAY) begin
      m_crc = crc_shift_byte(m_crc, w.data_byte);
    end
    if (p < POS_SAT) m_pos = p + 3'd1;
    if (!w.last_byte) return 1'b0;

    crc_out = ~m_crc;
    r = '{ST_OK, crc_out, m_rxctr};
    if (chk) begin
      if (p < POS_PAY) begin
        r = SHORT_RES;
      end else if (crc_out != m_rxcrc) begin
        r.status = ST_WRONG_CRC;
      end else begin
        if (m_rxctr == m_chk) r.status = ST_REPEATED;
        else if (m_rxctr < m_chk) r.status = ST_WRONG_SEQ;
        else if (m_rxctr - m_chk > m_maxd) r.status = ST_WRONG_SEQ;
        else r.status = ST_OK;
        m_chk = m_rxctr;
      end
    end
    m_crc = CRC_ONES;
    m_pos = POS_FIRST;
    return 1'b1;
  endfunction

  // Writes the little-endian CRC of the queued check frame into its bytes 0-3.
  function automatic void seal_frame();
    logic [31:0] c;
    c = crc_of_header(frame_q[4]);
    for (int i = 6; i < frame_q.size(); i++) c = crc_shift_byte(c, frame_q[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) frame_q[i] = c[8*i +: 8];
  endfunction

  task automatic send_word(in_word_t w, bit typed, res_word_t want);
    res_word_t r;
    in_if.valid     <= 1'b1;
    in_if.func      <= w.func;
    in_if.data_byte <= w.data_byte;
    in_if.last_byte <= w.last_byte;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (e2e_step(w, r)) due_results = {due_results, (typed ? want : r)};
    if (!calm && !burst && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(bit typed, res_word_t want);
    in_word_t w;
    for (int i = 0; i < frame_q.size(); i++) begin
      // The operation code only counts on the first byte; the others carry noise.
      w.func      = (i == 0) ? frame_func : FUNC_W'($urandom);
      w.data_byte = frame_q[i];
      w.last_byte = (i == frame_q.size() - 1);
      send_word(w, typed, want);
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DATA_ID) m_did = val[15:0];
    else m_maxd = val[6:0];
  endtask

  initial begin
    int       sel;
    int       plen;
    int       sent;
    int       idx;
    logic [3:0] rx;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.func      <= '0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    m_did   = '0;
    m_maxd  = MAX_DELTA_RST;
    m_crc   = CRC_ONES;
    m_pos   = POS_FIRST;
    m_op    = '0;
    m_snd   = '0;
    m_chk   = '0;
    m_rxcrc = '0;
    m_rxctr = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      frame_q.delete();
      frame_func = directed_rows[k].func;
      for (int i = 0; i < directed_rows[k].len; i++)
        frame_q = {frame_q, directed_rows[k].frame_bytes[8*i +: 8]};
      if (directed_rows[k].sealed) seal_frame();
      send_frame(directed_rows[k].typed, directed_rows[k].want);
    end
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          apb_write(REG_DATA_ID, 32'h0000_FFFF);
          apb_write(REG_MAX_DELTA, 32'd0);
        end
        1: begin
          apb_write(REG_DATA_ID, 32'h0000_0000);
          apb_write(REG_MAX_DELTA, 32'd127);
        end
        4: begin
          apb_write(REG_DATA_ID, 32'($urandom_range(0, 16'hFFFF)));
          apb_write(REG_MAX_DELTA, 32'd1);
        end
        default: begin
          apb_write(REG_DATA_ID, 32'($urandom_range(0, 16'hFFFF)));
          apb_write(REG_MAX_DELTA, 32'($urandom_range(0, 127)));
        end
      endcase
      calm = (phase == 4);

      if (phase == 1) begin
        // Back-to-back one-byte frames against a stalled receiver fill the block.
        hold_req = 1'b1;
        burst = 1'b1;
        repeat (16) begin
          frame_q.delete();
          frame_func = OP_PROTECT;
          frame_q = {frame_q, 8'($urandom)};
          send_frame(1'b0, IDLE_RES);
        end
        burst = 1'b0;
      end

      sent = 0;
      while (sent < 100) begin
        frame_q.delete();
        sel = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
        if (sel < 30) begin
          frame_func = (sel < 20) ? OP_PROTECT : OP_FORWARD;
          repeat (plen + 1) frame_q = {frame_q, 8'($urandom)};
        end else if (sel < 85) begin
          frame_func = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_CHECK;
          case ($urandom_range(0, 3))
            0: rx = m_chk;
            1: rx = m_chk + 4'd1;
            2: rx = m_chk + 4'($urandom_range(1, m_maxd + 2));
            default: rx = 4'($urandom);
          endcase
          repeat (4) frame_q = {frame_q, 8'h00};
          frame_q = {frame_q, {4'($urandom), rx}};
          frame_q = {frame_q, 8'($urandom)};
          repeat (plen) frame_q = {frame_q, 8'($urandom)};
          seal_frame();
          if (sel >= 75) begin
            // Corrupt one bit anywhere but the ignored byte 5.
            idx = $urandom_range(0, frame_q.size() - 1);
            if (idx == 5) idx = 0;
            frame_q[idx] = frame_q[idx] ^ (8'd1 << $urandom_range(0, 7));
          end
        end else if (sel < 93) begin
          frame_func = ($urandom_range(0, 1) == 0) ? OP_CHECK : OP_SPARE;
          repeat ($urandom_range(1, 6)) frame_q = {frame_q, 8'($urandom)};
        end else begin
          frame_func = op_e'($urandom_range(2, 3));
          repeat ($urandom_range(7, 12)) frame_q = {frame_q, 8'($urandom)};
        end
        sent += frame_q.size();
        send_frame(1'b0, IDLE_RES);
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (64) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    res_word_t exp_w;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result word with none expected: status %0d crc %h counter %0d",
               out_if.status, out_if.crc_value, out_if.counter_value);
        mismatch_cnt++;
      end else begin
        exp_w = due_results.pop_front();
        if (out_if.status !== exp_w.status) begin
          $error("status: expected %0d, actual %0d", exp_w.status, out_if.status);
          mismatch_cnt++;
        end
        if (out_if.crc_value !== exp_w.crc_value) begin
          $error("crc_value: expected %h, actual %h", exp_w.crc_value, out_if.crc_value);
          mismatch_cnt++;
        end
        if (out_if.counter_value !== exp_w.counter_value) begin
          $error("counter_value: expected %0d, actual %0d",
                 exp_w.counter_value, out_if.counter_value);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
